[design/ssrw_pkg.sv]
// Package for the staged stall recovery watchdog.
// Holds the item and result types, field codes and register reset values.
// No dependencies; every other design file refers to it by scoped names.
package ssrw_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned CNT_W = 32;
	localparam int unsigned POOL_W = 16;
	localparam int unsigned IN_DATA_W = 184;
	localparam int unsigned OUT_DATA_W = 136;

	localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd5000;
	localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd60000;

	localparam logic REG_CHECK_INTERVAL = 1'b0;
	localparam logic REG_STAGE_TIMEOUT = 1'b1;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_POLL = 1'b1;

	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_QUEUES = 2'd1;
	localparam logic [1:0] CMD_RADIO = 2'd2;
	localparam logic [1:0] CMD_REBOOT = 2'd3;

	localparam logic [1:0] STAGE_QUEUES = 2'd0;
	localparam logic [1:0] STAGE_RADIO = 2'd1;
	localparam logic [1:0] STAGE_REBOOT = 2'd2;

	// Input tdata layout, last member in the lowest bits.
	typedef struct packed {
		logic [6:0] pad;
		logic congested;
		logic [POOL_W-1:0] free_pool_packets;
		logic [CNT_W-1:0] recv_direct_count;
		logic [CNT_W-1:0] recv_flood_count;
		logic [CNT_W-1:0] sent_direct_count;
		logic [CNT_W-1:0] sent_flood_count;
		logic [TIME_W-1:0] now_ms;
	} in_data_t;

	// Output tdata layout, last member in the lowest bits.
	typedef struct packed {
		logic [4:0] pad;
		logic [CNT_W-1:0] reboot_total;
		logic [CNT_W-1:0] radio_recovery_total;
		logic [CNT_W-1:0] queue_recovery_total;
		logic [CNT_W-1:0] congestion_total;
		logic check_done;
		logic [1:0] command;
	} out_data_t;

	// One request after the input register, with the traffic total already formed.
	typedef struct packed {
		logic action;
		logic [TIME_W-1:0] now_ms;
		logic [CNT_W-1:0] traffic_sum;
		logic [POOL_W-1:0] free_pool_packets;
		logic congested;
	} item_t;

	typedef struct packed {
		logic [1:0] command;
		logic check_done;
		logic [CNT_W-1:0] congestion_total;
		logic [CNT_W-1:0] queue_recovery_total;
		logic [CNT_W-1:0] radio_recovery_total;
		logic [CNT_W-1:0] reboot_total;
	} result_t;

endpackage

[design/ssrw_ingress.sv]
// Input register of the watchdog: takes a request from the slave stream and
// forms the modulo 2^32 traffic total on the way in. Depends on ssrw_pkg.
module ssrw_ingress (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [ssrw_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic s_tuser,
	input  logic advance,
	output logic valid_s1,
	output ssrw_pkg::item_t item_s1
);

	ssrw_pkg::in_data_t din;
	logic [ssrw_pkg::CNT_W-1:0] sent_sum;
	logic [ssrw_pkg::CNT_W-1:0] recv_sum;
	logic accept;

	assign din = ssrw_pkg::in_data_t'(s_tdata);
	assign sent_sum = din.sent_flood_count + din.sent_direct_count;
	assign recv_sum = din.recv_flood_count + din.recv_direct_count;
	assign s_tready = !valid_s1 || advance;
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.action <= s_tuser;
			item_s1.now_ms <= din.now_ms;
			item_s1.traffic_sum <= sent_sum + recv_sum;
			item_s1.free_pool_packets <= din.free_pool_packets;
			item_s1.congested <= din.congested;
		end
	end

endmodule

[design/ssrw_core.sv]
// Watchdog state and decision logic: deadline check, progress tracking,
// escalation stage and event counters, plus the two configuration registers.
// Depends on ssrw_pkg.
module ssrw_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [ssrw_pkg::TIME_W-1:0] cfg_data,
	input  logic advance,
	input  ssrw_pkg::item_t item_s1,
	output ssrw_pkg::result_t result
);

	logic [ssrw_pkg::TIME_W-1:0] interval_q, timeout_q;
	logic [ssrw_pkg::TIME_W-1:0] deadline_q, progress_time_q, empty_since_q;
	logic [ssrw_pkg::CNT_W-1:0] snapshot_q;
	logic [1:0] stage_q;
	logic [ssrw_pkg::CNT_W-1:0] cong_cnt_q, queue_cnt_q, radio_cnt_q, reboot_cnt_q;

	logic [ssrw_pkg::TIME_W-1:0] deadline_d, progress_time_d, empty_since_d;
	logic [ssrw_pkg::CNT_W-1:0] snapshot_d;
	logic [1:0] stage_d;
	logic [ssrw_pkg::CNT_W-1:0] cong_cnt_d, queue_cnt_d, radio_cnt_d, reboot_cnt_d;

	logic [ssrw_pkg::TIME_W-1:0] now, since_deadline, next_deadline;
	logic [ssrw_pkg::TIME_W-1:0] es_a, es_b, pt_a;
	logic [1:0] st_a;
	logic due, progress, quiet_long, elapsed;
	logic [1:0] command;
	logic done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= ssrw_pkg::INTERVAL_RESET;
			timeout_q <= ssrw_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ssrw_pkg::REG_CHECK_INTERVAL: interval_q <= cfg_data;
				ssrw_pkg::REG_STAGE_TIMEOUT: timeout_q <= cfg_data;
				default: interval_q <= interval_q;
			endcase
		end
	end

	assign now = item_s1.now_ms;
	assign since_deadline = now - deadline_q;
	assign next_deadline = now + interval_q;
	assign due = !since_deadline[ssrw_pkg::TIME_W-1];
	assign progress = item_s1.traffic_sum != snapshot_q;

	always_comb begin
		deadline_d = deadline_q;
		progress_time_d = progress_time_q;
		empty_since_d = empty_since_q;
		snapshot_d = snapshot_q;
		stage_d = stage_q;
		cong_cnt_d = cong_cnt_q;
		queue_cnt_d = queue_cnt_q;
		radio_cnt_d = radio_cnt_q;
		reboot_cnt_d = reboot_cnt_q;
		command = ssrw_pkg::CMD_NONE;
		done = 1'b0;

		es_a = progress ? '0 : empty_since_q;
		st_a = progress ? ssrw_pkg::STAGE_QUEUES : stage_q;
		pt_a = progress ? now : progress_time_q;
		es_b = (es_a == '0) ? now : es_a;
		quiet_long = (now - pt_a) >= timeout_q;
		elapsed = (now - es_b) >= timeout_q;

		if (item_s1.action == ssrw_pkg::ACT_START) begin
			deadline_d = next_deadline;
			progress_time_d = now;
			snapshot_d = item_s1.traffic_sum;
		end else if (due) begin
			done = 1'b1;
			deadline_d = next_deadline;
			snapshot_d = item_s1.traffic_sum;
			progress_time_d = pt_a;
			if (item_s1.congested) begin
				cong_cnt_d = cong_cnt_q + 1'b1;
			end
			if (item_s1.free_pool_packets != '0) begin
				empty_since_d = '0;
				stage_d = ssrw_pkg::STAGE_QUEUES;
			end else begin
				empty_since_d = es_b;
				stage_d = st_a;
				if (quiet_long && elapsed) begin
					case (st_a)
						ssrw_pkg::STAGE_QUEUES: begin
							command = ssrw_pkg::CMD_QUEUES;
							queue_cnt_d = queue_cnt_q + 1'b1;
							stage_d = ssrw_pkg::STAGE_RADIO;
							empty_since_d = now;
						end
						ssrw_pkg::STAGE_RADIO: begin
							command = ssrw_pkg::CMD_RADIO;
							radio_cnt_d = radio_cnt_q + 1'b1;
							stage_d = ssrw_pkg::STAGE_REBOOT;
							empty_since_d = now;
						end
						default: begin
							command = ssrw_pkg::CMD_REBOOT;
							reboot_cnt_d = reboot_cnt_q + 1'b1;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadline_q <= '0;
			progress_time_q <= '0;
			empty_since_q <= '0;
			snapshot_q <= '0;
			stage_q <= ssrw_pkg::STAGE_QUEUES;
			cong_cnt_q <= '0;
			queue_cnt_q <= '0;
			radio_cnt_q <= '0;
			reboot_cnt_q <= '0;
		end else if (advance) begin
			deadline_q <= deadline_d;
			progress_time_q <= progress_time_d;
			empty_since_q <= empty_since_d;
			snapshot_q <= snapshot_d;
			stage_q <= stage_d;
			cong_cnt_q <= cong_cnt_d;
			queue_cnt_q <= queue_cnt_d;
			radio_cnt_q <= radio_cnt_d;
			reboot_cnt_q <= reboot_cnt_d;
		end
	end

	assign result.command = command;
	assign result.check_done = done;
	assign result.congestion_total = cong_cnt_d;
	assign result.queue_recovery_total = queue_cnt_d;
	assign result.radio_recovery_total = radio_cnt_d;
	assign result.reboot_total = reboot_cnt_d;

endmodule

[design/staged_stall_recovery_watchdog.sv]
// Top level of the staged stall recovery watchdog: stream ports, output register.
// Instantiates ssrw_ingress and ssrw_core; depends on ssrw_pkg.
//
// Every request (start or poll) yields exactly one result on the master side. The
// block takes one request per cycle unless a result waits on m_tready: the input
// register forms the traffic total, and the state update and result are computed
// in one pass from that register into the output register. A result waiting on
// m_tready holds the output register, and the input register takes one more
// request before s_tready drops. The configuration
// registers are written through cfg_we/cfg_index/cfg_data and should only be
// changed while no request is in flight.
module staged_stall_recovery_watchdog (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [ssrw_pkg::TIME_W-1:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	// now_ms, sent_flood_count, sent_direct_count, recv_flood_count,
	// recv_direct_count, free_pool_packets, congested, zero fill
	input  logic [ssrw_pkg::IN_DATA_W-1:0] s_tdata,
	// action
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// command, check_done, congestion_total, queue_recovery_total,
	// radio_recovery_total, reboot_total, zero fill
	output logic [ssrw_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic valid_s1;
	logic advance;
	ssrw_pkg::item_t item_s1;
	ssrw_pkg::result_t result;
	ssrw_pkg::result_t res_q;
	logic out_valid_q;
	ssrw_pkg::out_data_t dout;

	assign advance = valid_s1 && (!out_valid_q || m_tready);

	ssrw_ingress u_ingress (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.advance(advance),
		.valid_s1(valid_s1),
		.item_s1(item_s1)
	);

	ssrw_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.advance(advance),
		.item_s1(item_s1),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	always_comb begin
		dout.pad = '0;
		dout.command = res_q.command;
		dout.check_done = res_q.check_done;
		dout.congestion_total = res_q.congestion_total;
		dout.queue_recovery_total = res_q.queue_recovery_total;
		dout.radio_recovery_total = res_q.radio_recovery_total;
		dout.reboot_total = res_q.reboot_total;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = dout;

endmodule

[design/ssrw_checker.sv]
// Port-level checker for the staged stall recovery watchdog, with its bind.
// Depends on ssrw_pkg and on the top level's port list.
module ssrw_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tready,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [ssrw_pkg::OUT_DATA_W-1:0] m_tdata
);

	ssrw_pkg::out_data_t dout;
	assign dout = ssrw_pkg::out_data_t'(m_tdata);

	// A recovery command only comes out of a poll that reached its deadline.
	a_cmd_needs_check: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (dout.command != ssrw_pkg::CMD_NONE) |-> dout.check_done)
		else $error("recovery command without a completed check");

	// The input side only stalls when a result is waiting on the output side.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while output is free");

	// The zero fill of the result stays zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (dout.pad == '0))
		else $error("nonzero fill bits in result");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind staged_stall_recovery_watchdog ssrw_checker u_ssrw_checker (.*);

[sim/tb_staged_stall_recovery_watchdog.sv]
// Testbench for staged_stall_recovery_watchdog: directed and random start/poll requests,
// each predicted in the bench and checked field by field against the result stream.
// Depends on ssrw_pkg and the design top level; self-contained otherwise.
module tb_staged_stall_recovery_watchdog;

	localparam int unsigned HOLD_CYCLES = 200;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned PHASE_ITEMS = 165;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = ssrw_pkg::REG_CHECK_INTERVAL;
	logic [ssrw_pkg::TIME_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// now_ms, sent_flood_count, sent_direct_count, recv_flood_count,
	// recv_direct_count, free_pool_packets, congested, zero fill
	logic [ssrw_pkg::IN_DATA_W-1:0] s_tdata = '0;
	// action
	logic s_tuser = ssrw_pkg::ACT_START;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// command, check_done, congestion_total, queue_recovery_total,
	// radio_recovery_total, reboot_total, zero fill
	logic [ssrw_pkg::OUT_DATA_W-1:0] m_tdata;

	// Predicted watchdog state and configuration.
	logic [31:0] cur_interval = ssrw_pkg::INTERVAL_RESET;
	logic [31:0] cur_timeout = ssrw_pkg::TIMEOUT_RESET;
	logic [31:0] deadline_at = '0;
	logic [31:0] progress_at = '0;
	logic [31:0] traffic_seen = '0;
	logic [31:0] empty_at = '0;
	logic [1:0] esc_stage = ssrw_pkg::STAGE_QUEUES;
	logic [31:0] cnt_congested = '0;
	logic [31:0] cnt_queue = '0;
	logic [31:0] cnt_radio = '0;
	logic [31:0] cnt_reboot = '0;

	ssrw_pkg::out_data_t pending_results[$];
	int unsigned fail_count = 0;
	int unsigned burst_left = 0;
	bit bursty = 1'b1;
	bit hold_request = 1'b0;

	staged_stall_recovery_watchdog u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic ssrw_pkg::out_data_t watchdog_step(input logic act,
			input ssrw_pkg::in_data_t d);
		ssrw_pkg::out_data_t r;
		logic [31:0] total;
		logic [31:0] past_deadline;
		logic [31:0] quiet_for;
		logic [31:0] empty_for;
		r = '0;
		total = d.sent_flood_count + d.sent_direct_count + d.recv_flood_count
			+ d.recv_direct_count;
		past_deadline = d.now_ms - deadline_at;
		r.command = ssrw_pkg::CMD_NONE;
		if (act == ssrw_pkg::ACT_START) begin
			deadline_at = d.now_ms + cur_interval;
			progress_at = d.now_ms;
			traffic_seen = total;
		end else if (!past_deadline[31]) begin
			r.check_done = 1'b1;
			deadline_at = d.now_ms + cur_interval;
			if (total != traffic_seen) begin
				traffic_seen = total;
				progress_at = d.now_ms;
				empty_at = '0;
				esc_stage = ssrw_pkg::STAGE_QUEUES;
			end
			if (d.congested)
				cnt_congested = cnt_congested + 1;
			if (d.free_pool_packets != '0) begin
				empty_at = '0;
				esc_stage = ssrw_pkg::STAGE_QUEUES;
			end else begin
				if (empty_at == '0)
					empty_at = d.now_ms;
				quiet_for = d.now_ms - progress_at;
				empty_for = d.now_ms - empty_at;
				if (quiet_for >= cur_timeout && empty_for >= cur_timeout) begin
					case (esc_stage)
						ssrw_pkg::STAGE_QUEUES: begin
							r.command = ssrw_pkg::CMD_QUEUES;
							cnt_queue = cnt_queue + 1;
							esc_stage = ssrw_pkg::STAGE_RADIO;
							empty_at = d.now_ms;
						end
						ssrw_pkg::STAGE_RADIO: begin
							r.command = ssrw_pkg::CMD_RADIO;
							cnt_radio = cnt_radio + 1;
							esc_stage = ssrw_pkg::STAGE_REBOOT;
							empty_at = d.now_ms;
						end
						default: begin
							r.command = ssrw_pkg::CMD_REBOOT;
							cnt_reboot = cnt_reboot + 1;
						end
					endcase
				end
			end
		end
		r.congestion_total = cnt_congested;
		r.queue_recovery_total = cnt_queue;
		r.radio_recovery_total = cnt_radio;
		r.reboot_total = cnt_reboot;
		return r;
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endfunction

	task automatic send_item(input logic act, input logic [31:0] now,
			input logic [31:0] sf, input logic [31:0] sd, input logic [31:0] rf,
			input logic [31:0] rd, input logic [15:0] pool, input logic cong);
		ssrw_pkg::in_data_t d;
		int unsigned gap;
		d = '0;
		d.now_ms = now;
		d.sent_flood_count = sf;
		d.sent_direct_count = sd;
		d.recv_flood_count = rf;
		d.recv_direct_count = rd;
		d.free_pool_packets = pool;
		d.congested = cong;
		if (bursty && burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left != 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= act;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(watchdog_step(act, d));
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [31:0] interval, input logic [31:0] timeout);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= ssrw_pkg::REG_CHECK_INTERVAL;
		cfg_data <= interval;
		@(posedge clk);
		cfg_index <= ssrw_pkg::REG_STAGE_TIMEOUT;
		cfg_data <= timeout;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_interval = interval;
		cur_timeout = timeout;
	endtask

	// A station that runs from t0 with slowly moving traffic and a mostly empty pool,
	// mixed with restarts and fully random requests.
	task automatic run_station(input int unsigned n_items, input logic [31:0] t0);
		logic [31:0] t;
		logic [31:0] tc[4];
		logic [15:0] pool;
		int unsigned span;
		int unsigned roll;
		int unsigned j;
		t = t0;
		for (j = 0; j < 4; j++)
			tc[j] = $urandom;
		span = (cur_interval > 1000) ? 40 : cur_interval;
		send_item(ssrw_pkg::ACT_START, t, tc[0], tc[1], tc[2], tc[3], 16'd0, 1'b0);
		for (int unsigned k = 1; k < n_items; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 5) begin
				send_item(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
					$urandom, $urandom, 16'($urandom_range(0, 65535)),
					1'($urandom_range(0, 1)));
			end else if (roll < 10) begin
				send_item(ssrw_pkg::ACT_START, t, tc[0], tc[1], tc[2], tc[3], 16'd0,
					1'($urandom_range(0, 1)));
			end else begin
				t = t + $urandom_range(0, 2 * span + 1);
				if ($urandom_range(0, 99) < 12) begin
					j = $urandom_range(0, 3);
					tc[j] = tc[j] + $urandom_range(1, 3);
				end
				pool = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535)) : 16'd0;
				send_item(ssrw_pkg::ACT_POLL, t, tc[0], tc[1], tc[2], tc[3], pool,
					1'($urandom_range(0, 1)));
			end
		end
	endtask

	// Reset configuration: empty pool seen at time zero, a poll before its deadline,
	// then a first escalation after the full default timeout.
	task automatic test_default_settings;
		send_item(ssrw_pkg::ACT_POLL, 32'd0, '0, '0, '0, '0, 16'd0, 1'b1);
		send_item(ssrw_pkg::ACT_POLL, 32'd1, '0, '0, '0, '0, 16'd0, 1'b0);
		send_item(ssrw_pkg::ACT_START, 32'd100, '0, '0, '0, '0, 16'd0, 1'b0);
		send_item(ssrw_pkg::ACT_POLL, 32'd5099, '0, '0, '0, '0, 16'd0, 1'b1);
		send_item(ssrw_pkg::ACT_POLL, 32'd5100, '0, '0, '0, '0, 16'd0, 1'b0);
		send_item(ssrw_pkg::ACT_POLL, 32'd65100, '0, '0, '0, '0, 16'd0, 1'b1);
	endtask

	// Walks all stages, repeats reboot, then clears on progress and on a full pool.
	task automatic test_escalation;
		configure(32'd10, 32'd50);
		send_item(ssrw_pkg::ACT_START, 32'd1000, 32'd1, 32'd2, 32'd3, 32'd4, 16'd0, 1'b0);
		send_item(ssrw_pkg::ACT_POLL, 32'd1010, 32'd1, 32'd2, 32'd3, 32'd4, 16'd0, 1'b0);
		send_item(ssrw_pkg::ACT_POLL, 32'd1060, 32'd1, 32'd2, 32'd3, 32'd4, 16'd0, 1'b1);
		send_item(ssrw_pkg::ACT_POLL, 32'd1110, 32'd1, 32'd2, 32'd3, 32'd4, 16'd0, 1'b0);
		send_item(ssrw_pkg::ACT_POLL, 32'd1160, 32'd1, 32'd2, 32'd3, 32'd4, 16'd0, 1'b0);
		send_item(ssrw_pkg::ACT_POLL, 32'd1170, 32'd1, 32'd2, 32'd3, 32'd4, 16'd0, 1'b0);
		send_item(ssrw_pkg::ACT_POLL, 32'd1210, 32'd1, 32'd2, 32'd3, 32'd4, 16'd0, 1'b1);
		send_item(ssrw_pkg::ACT_POLL, 32'd1220, 32'd1, 32'd2, 32'd3, 32'd5, 16'd0, 1'b0);
		send_item(ssrw_pkg::ACT_POLL, 32'd1230, 32'd1, 32'd2, 32'd3, 32'd5, 16'hFFFF,
			1'b0);
	endtask

	// Largest interval with a zero timeout, wrapping time and traffic sums, and the
	// half-range boundary of the deadline compare.
	task automatic test_field_extremes;
		configure(32'hFFFF_FFFF, 32'd0);
		send_item(ssrw_pkg::ACT_START, 32'hFFFF_FFFF, '1, '1, '1, '1, 16'd0, 1'b1);
		send_item(ssrw_pkg::ACT_POLL, 32'd0, '1, '1, '1, '1, 16'd0, 1'b1);
		send_item(ssrw_pkg::ACT_POLL, 32'd1, '1, '1, '1, '1, 16'd0, 1'b0);
		send_item(ssrw_pkg::ACT_POLL, 32'd2, '1, '1, '1, '1, 16'd0, 1'b1);
		send_item(ssrw_pkg::ACT_POLL, 32'h7FFF_FFFF, '1, '1, '1, '1, 16'd0, 1'b0);
		send_item(ssrw_pkg::ACT_POLL, 32'h8000_0001, '1, '1, '1, '1, 16'hFFFF, 1'b0);
		configure(32'd1, 32'hFFFF_FFFF);
		send_item(ssrw_pkg::ACT_START, 32'd0, '0, '0, '0, '0, 16'd0, 1'b0);
		send_item(ssrw_pkg::ACT_POLL, 32'h8000_0001, '0, '0, '0, '0, 16'd0, 1'b1);
	endtask

	task automatic test_random_traffic;
		configure(32'd1, 32'd1);
		run_station(PHASE_ITEMS, $urandom);
		configure(32'd10, 32'd60);
		run_station(PHASE_ITEMS, $urandom);
		configure(32'd20, 32'd0);
		run_station(PHASE_ITEMS, $urandom);
		configure(32'hFFFF_FFFF, 32'd30);
		run_station(PHASE_ITEMS, $urandom);
		configure(32'd5, 32'hFFFF_FFFF);
		run_station(PHASE_ITEMS, $urandom);
		configure(32'd3, 32'd25);
		run_station(PHASE_ITEMS, 32'hFFFF_F800);
		configure($urandom_range(1, 30), $urandom_range(1, 150));
		run_station(PHASE_ITEMS, $urandom);
		configure($urandom_range(1, 30), $urandom_range(1, 150));
		run_station(PHASE_ITEMS, $urandom);
	endtask

	// The receiver holds off while requests keep coming, so the input side stalls.
	task automatic test_output_backpressure;
		configure(32'd2, 32'd20);
		bursty = 1'b0;
		hold_request = 1'b1;
		run_station(80, $urandom);
		bursty = 1'b1;
	endtask

	always @(posedge clk) begin : ready_pattern
		static int unsigned hold_left = 0;
		static int unsigned beat = 0;
		static int unsigned mode = 0;
		beat++;
		if (beat % 64 == 0)
			mode = $urandom_range(0, 3);
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (beat % 5 != 0);
			endcase
		end
	end

	always @(posedge clk) begin : result_check
		ssrw_pkg::out_data_t got;
		ssrw_pkg::out_data_t want;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected result: cmd %0d done %0d", got.command,
					got.check_done));
			end else begin
				want = pending_results.pop_front();
				if (got.command != want.command || got.check_done != want.check_done
						|| got.congestion_total != want.congestion_total
						|| got.queue_recovery_total != want.queue_recovery_total
						|| got.radio_recovery_total != want.radio_recovery_total
						|| got.reboot_total != want.reboot_total)
					note_failure({$sformatf(
						"mismatch: expected cmd %0d done %0d totals %0d %0d %0d %0d",
						want.command, want.check_done, want.congestion_total,
						want.queue_recovery_total, want.radio_recovery_total,
						want.reboot_total), $sformatf(
						", got cmd %0d done %0d totals %0d %0d %0d %0d",
						got.command, got.check_done,
						got.congestion_total, got.queue_recovery_total,
						got.radio_recovery_total, got.reboot_total)});
			end
		end
	end

	always @(posedge clk) begin : quiet_watch
		static int unsigned quiet = 0;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet = 0;
		else
			quiet++;
		if (quiet == QUIET_LIMIT) begin
			$display("timeout with %0d results outstanding", pending_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_settings();
		test_escalation();
		test_field_extremes();
		test_output_backpressure();
		test_random_traffic();
		drain();
		repeat (6) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
